### rtl/datetime_text_parser_top_macros.svh
// Assertion macros for the date-time text parser.
// Used by datetime_text_parser_top; expects a clock and reset in scope.
`ifndef DATETIME_TEXT_PARSER_TOP_MACROS_SVH
`define DATETIME_TEXT_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define DTTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dttp_pkg.sv
// Types and constants for the date-time text parser.
// No dependencies.
package dttp_pkg;

   typedef enum logic [2:0] {
      PH_DAY,
      PH_MONTH,
      PH_YEAR,
      PH_HOUR,
      PH_MINUTE,
      PH_SECOND,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [6:0]  day;
      logic [6:0]  month;
      logic [13:0] year;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [5:0]  fields_set;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  char_count;
      phase_type   phase;
      logic [2:0]  digits;
      logic [4:0]  month_end_pos;
      logic [6:0]  day_acc;
      logic [6:0]  month_acc;
      logic [13:0] year_acc;
      logic [6:0]  hour_acc;
      logic [6:0]  minute_acc;
      logic [6:0]  second_acc;
      logic [5:0]  pending_mask;
      logic        stopped;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      char_count:    5'd0,
      phase:         PH_DAY,
      digits:        3'd0,
      month_end_pos: 5'd0,
      day_acc:       7'd0,
      month_acc:     7'd0,
      year_acc:      14'd0,
      hour_acc:      7'd0,
      minute_acc:    7'd0,
      second_acc:    7'd0,
      pending_mask:  6'd0,
      stopped:       1'b0
   };

   localparam logic [4:0] COUNT_MAX = 5'd31;
   localparam logic [4:0] MIN_LEN   = 5'd17;
   localparam logic [5:0] TAIL_LEN  = 6'd13;
   localparam logic [2:0] YEAR_DIGITS = 3'd4;
   localparam logic [2:0] PAIR_DIGITS = 3'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [5:0] MASK_DAY    = 6'b000001;
   localparam logic [5:0] MASK_MONTH  = 6'b000010;
   localparam logic [5:0] MASK_YEAR   = 6'b000100;
   localparam logic [5:0] MASK_HOUR   = 6'b001000;
   localparam logic [5:0] MASK_MINUTE = 6'b010000;
   localparam logic [5:0] MASK_SECOND = 6'b100000;
   localparam logic [5:0] MASK_DATE   = 6'b000011;
   localparam logic [5:0] MASK_TAIL   = 6'b111100;

endpackage

### rtl/datetime_text_parser_top.sv
// Date-time text parser, top level: parses D/M/YYYY HH:MM:SS one character a request.
// Depends on dttp_pkg and datetime_text_parser_top_macros.svh.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_data  (character, last)
//  rsp     | out | rsp_valid/rsp_ready  | rsp_data  (six fields, fields_set)
//
// One character per cycle while req_ready is high; the parse state updates in the cycle a request is taken.
// The result of a last character is registered in the output register, or in the skid entry while the output stalls.
// A two-entry output buffer (output register plus skid) holds results;
// req_ready drops only while the skid entry is occupied.
// Synchronous active-high reset returns the parser to the start of a string.
`include "datetime_text_parser_top_macros.svh"

module datetime_text_parser_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dttp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dttp_pkg::rsp_type rsp_data
);

   dttp_pkg::parse_state_type state_ff, state_in;
   dttp_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   dttp_pkg::rsp_type         skid_data_ff, skid_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   dttp_pkg::rsp_type         result;
   logic                      accept;
   logic                      produce;

   function automatic logic [13:0] times_ten(input logic [13:0] v);
      return (v << 3) + (v << 1);
   endfunction

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign produce   = accept && req_data.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // parse step
   always_comb begin
      dttp_pkg::parse_state_type nxt;
      logic [7:0]  c;
      logic        is_dig;
      logic [13:0] d;
      logic [6:0]  short_acc;
      logic [6:0]  short_new;
      logic [6:0]  pair_acc;
      logic [6:0]  pair_new;
      logic [2:0]  dig_next;
      logic [5:0]  mask;
      logic [5:0]  tail_end;

      nxt       = state_ff;
      c         = req_data.character;
      is_dig    = (c >= dttp_pkg::CH_ZERO) && (c <= dttp_pkg::CH_NINE);
      d         = {10'd0, c[3:0]};
      short_acc = (state_ff.phase == dttp_pkg::PH_DAY) ? state_ff.day_acc : state_ff.month_acc;
      short_new = 7'd0;
      case (state_ff.phase)
         dttp_pkg::PH_HOUR:   pair_acc = state_ff.hour_acc;
         dttp_pkg::PH_MINUTE: pair_acc = state_ff.minute_acc;
         default:             pair_acc = state_ff.second_acc;
      endcase
      pair_new  = 7'd0;
      dig_next  = state_ff.digits + 3'd1;

      if (!state_ff.stopped) begin
         case (state_ff.phase)
            dttp_pkg::PH_DAY, dttp_pkg::PH_MONTH: begin
               if (state_ff.digits == 3'd0) begin
                  if (is_dig) begin
                     short_new = d[6:0];
                     nxt.digits = 3'd1;
                     nxt.pending_mask = state_ff.pending_mask |
                        ((state_ff.phase == dttp_pkg::PH_DAY) ?
                         dttp_pkg::MASK_DAY : dttp_pkg::MASK_MONTH);
                  end else begin
                     nxt.stopped = 1'b1;
                  end
               end else if (state_ff.digits == 3'd1 && is_dig) begin
                  short_new = 7'(times_ten(14'(short_acc)) + d);
                  nxt.digits = 3'd2;
               end else if (c == dttp_pkg::CH_SLASH) begin
                  nxt.digits = 3'd0;
                  if (state_ff.phase == dttp_pkg::PH_DAY) begin
                     nxt.phase = dttp_pkg::PH_MONTH;
                  end else begin
                     nxt.phase = dttp_pkg::PH_YEAR;
                     nxt.month_end_pos = state_ff.char_count + 5'd1;
                  end
               end else begin
                  nxt.stopped = 1'b1;
               end
               if (state_ff.digits < 3'd2 && is_dig) begin
                  if (state_ff.phase == dttp_pkg::PH_DAY) begin
                     nxt.day_acc = short_new;
                  end else begin
                     nxt.month_acc = short_new;
                  end
               end
            end
            dttp_pkg::PH_YEAR: begin
               if (state_ff.digits < dttp_pkg::YEAR_DIGITS) begin
                  if (is_dig) begin
                     nxt.year_acc = (state_ff.digits == 3'd0) ? d :
                                    times_ten(state_ff.year_acc) + d;
                     nxt.digits = dig_next;
                     if (dig_next == dttp_pkg::YEAR_DIGITS) begin
                        nxt.pending_mask = state_ff.pending_mask | dttp_pkg::MASK_YEAR;
                     end
                  end else begin
                     nxt.stopped = 1'b1;
                  end
               end else if (c == dttp_pkg::CH_SPACE) begin
                  nxt.phase  = dttp_pkg::PH_HOUR;
                  nxt.digits = 3'd0;
               end else begin
                  nxt.stopped = 1'b1;
               end
            end
            dttp_pkg::PH_HOUR, dttp_pkg::PH_MINUTE, dttp_pkg::PH_SECOND: begin
               if (state_ff.digits < dttp_pkg::PAIR_DIGITS) begin
                  if (is_dig) begin
                     pair_new = (state_ff.digits == 3'd0) ? d[6:0] :
                                7'(times_ten(14'(pair_acc)) + d);
                     nxt.digits = dig_next;
                     case (state_ff.phase)
                        dttp_pkg::PH_HOUR:   nxt.hour_acc   = pair_new;
                        dttp_pkg::PH_MINUTE: nxt.minute_acc = pair_new;
                        default:             nxt.second_acc = pair_new;
                     endcase
                     if (dig_next == dttp_pkg::PAIR_DIGITS) begin
                        case (state_ff.phase)
                           dttp_pkg::PH_HOUR:
                              nxt.pending_mask = state_ff.pending_mask | dttp_pkg::MASK_HOUR;
                           dttp_pkg::PH_MINUTE:
                              nxt.pending_mask = state_ff.pending_mask | dttp_pkg::MASK_MINUTE;
                           default: begin
                              nxt.pending_mask = state_ff.pending_mask | dttp_pkg::MASK_SECOND;
                              nxt.phase  = dttp_pkg::PH_DONE;
                              nxt.digits = 3'd0;
                           end
                        endcase
                     end
                  end else begin
                     nxt.stopped = 1'b1;
                  end
               end else if (c == dttp_pkg::CH_COLON &&
                            state_ff.phase != dttp_pkg::PH_SECOND) begin
                  nxt.phase  = (state_ff.phase == dttp_pkg::PH_HOUR) ?
                               dttp_pkg::PH_MINUTE : dttp_pkg::PH_SECOND;
                  nxt.digits = 3'd0;
               end else begin
                  nxt.stopped = 1'b1;
               end
            end
            default: begin
               nxt.stopped = 1'b1;
            end
         endcase
      end

      nxt.char_count = (state_ff.char_count == dttp_pkg::COUNT_MAX) ?
                       dttp_pkg::COUNT_MAX : state_ff.char_count + 5'd1;

      // result from the updated state
      tail_end = {1'b0, nxt.month_end_pos} + dttp_pkg::TAIL_LEN;
      mask     = 6'd0;
      if (nxt.char_count >= dttp_pkg::MIN_LEN) begin
         mask = nxt.pending_mask & dttp_pkg::MASK_DATE;
         if (nxt.month_end_pos != 5'd0 && {1'b0, nxt.char_count} == tail_end) begin
            mask = mask | (nxt.pending_mask & dttp_pkg::MASK_TAIL);
         end
      end
      result.day        = mask[0] ? nxt.day_acc    : 7'd0;
      result.month      = mask[1] ? nxt.month_acc  : 7'd0;
      result.year       = mask[2] ? nxt.year_acc   : 14'd0;
      result.hour       = mask[3] ? nxt.hour_acc   : 7'd0;
      result.minute     = mask[4] ? nxt.minute_acc : 7'd0;
      result.second     = mask[5] ? nxt.second_acc : 7'd0;
      result.fields_set = mask;

      if (!accept) begin
         state_in = state_ff;
      end else if (req_data.last) begin
         state_in = dttp_pkg::PARSE_RESET;
      end else begin
         state_in = nxt;
      end
   end

   // output register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && !rsp_ready) begin
         if (produce) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = produce;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dttp_pkg::PARSE_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `DTTP_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid full with empty output")
   `DTTP_ASSERT_NEXT(a_reset_after_last, accept && req_data.last,
      state_ff == dttp_pkg::PARSE_RESET, "parser not restarted after last character")
   `DTTP_ASSERT_NEXT(a_stop_sticks, accept && !req_data.last && state_ff.stopped,
      state_ff.stopped, "stopped flag cleared inside a string")
   `DTTP_ASSERT_NOW(a_tail_needs_date, rsp_valid_ff && (rsp_data_ff.fields_set[5:2] != 4'd0),
      rsp_data_ff.fields_set[1:0] == 2'b11, "time fields set without day and month")

endmodule

### dv/datetime_text_parser_top_tb.sv
// Self-checking testbench for datetime_text_parser_top: character requests in, parsed dates out.
// Uses dttp_pkg types; checks every result field by field against its own prediction or a directed table entry.
`timescale 1ns / 1ps

module datetime_text_parser_top_tb;

   typedef logic [7:0] text_q_type[$];

   typedef struct {
      string             text;
      logic [7:0]        lone_char;
      bit                typed;
      dttp_pkg::rsp_type want;
   } dir_row_type;

   localparam int CHAR_TARGET    = 1400;
   localparam int PAUSE_AT_TEXT  = 60;
   localparam int HOLD_AT_RESULT = 10;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dttp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dttp_pkg::rsp_type rsp_data;

   datetime_text_parser_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dttp_pkg::rsp_type pending_dates[$];
   dir_row_type       dir_rows[4];
   int         mismatches, chars_sent, texts_sent, dates_checked;
   int         full_dates, empty_dates, burst_left, quiet_cycles;

   // predicted parser state
   logic [4:0]          seen_len;
   dttp_pkg::phase_type field_phase;
   int                  field_digits;
   logic [4:0]          slash_pos;
   int         day_v, month_v, year_v, hour_v, minute_v, second_v;
   logic [5:0] done_mask;
   bit         halted;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= dttp_pkg::CH_ZERO && c <= dttp_pkg::CH_NINE;
   endfunction

   task automatic restart_parse();
      seen_len = '0;
      field_phase = dttp_pkg::PH_DAY;
      field_digits = 0;
      slash_pos = '0;
      day_v = 0;
      month_v = 0;
      year_v = 0;
      hour_v = 0;
      minute_v = 0;
      second_v = 0;
      done_mask = '0;
      halted = 1'b0;
   endtask

   // day or month: one or two digits, then a slash
   task automatic take_short(input logic [7:0] c, inout int acc, input logic [5:0] flag,
                             input dttp_pkg::phase_type nxt);
      if (field_digits == 0) begin
         if (is_digit(c)) begin
            acc = c - dttp_pkg::CH_ZERO;
            field_digits = 1;
            done_mask |= flag;
         end else begin
            halted = 1'b1;
         end
      end else if (field_digits == 1 && is_digit(c)) begin
         acc = (acc * 10 + (c - dttp_pkg::CH_ZERO)) % 128;
         field_digits = 2;
      end else if (c == dttp_pkg::CH_SLASH) begin
         field_phase = nxt;
         field_digits = 0;
         if (nxt == dttp_pkg::PH_YEAR)
            slash_pos = seen_len + 5'd1;
      end else begin
         halted = 1'b1;
      end
   endtask

   // fixed digit count, then an optional separator
   task automatic take_fixed(input logic [7:0] c, inout int acc, input int ndig,
                             input logic [5:0] flag, input logic [7:0] sep,
                             input bit has_sep, input dttp_pkg::phase_type nxt);
      if (field_digits < ndig) begin
         if (is_digit(c)) begin
            acc = (field_digits == 0 ? 0 : acc * 10) + (c - dttp_pkg::CH_ZERO);
            field_digits++;
            if (field_digits == ndig) begin
               done_mask |= flag;
               if (!has_sep) begin
                  field_phase = nxt;
                  field_digits = 0;
               end
            end
         end else begin
            halted = 1'b1;
         end
      end else if (has_sep && c == sep) begin
         field_phase = nxt;
         field_digits = 0;
      end else begin
         halted = 1'b1;
      end
   endtask

   task automatic parse_char(input dttp_pkg::req_type it, output bit got,
                             output dttp_pkg::rsp_type res);
      int         len;
      logic [5:0] m;
      got = 1'b0;
      res = '0;
      if (!halted) begin
         case (field_phase)
            dttp_pkg::PH_DAY:
               take_short(it.character, day_v, dttp_pkg::MASK_DAY, dttp_pkg::PH_MONTH);
            dttp_pkg::PH_MONTH:
               take_short(it.character, month_v, dttp_pkg::MASK_MONTH, dttp_pkg::PH_YEAR);
            dttp_pkg::PH_YEAR:
               take_fixed(it.character, year_v, dttp_pkg::YEAR_DIGITS, dttp_pkg::MASK_YEAR,
                          dttp_pkg::CH_SPACE, 1'b1, dttp_pkg::PH_HOUR);
            dttp_pkg::PH_HOUR:
               take_fixed(it.character, hour_v, dttp_pkg::PAIR_DIGITS, dttp_pkg::MASK_HOUR,
                          dttp_pkg::CH_COLON, 1'b1, dttp_pkg::PH_MINUTE);
            dttp_pkg::PH_MINUTE:
               take_fixed(it.character, minute_v, dttp_pkg::PAIR_DIGITS,
                          dttp_pkg::MASK_MINUTE, dttp_pkg::CH_COLON, 1'b1,
                          dttp_pkg::PH_SECOND);
            dttp_pkg::PH_SECOND:
               take_fixed(it.character, second_v, dttp_pkg::PAIR_DIGITS,
                          dttp_pkg::MASK_SECOND, 8'h00, 1'b0, dttp_pkg::PH_DONE);
            default:   halted = 1'b1;
         endcase
      end
      len = (seen_len == dttp_pkg::COUNT_MAX) ? dttp_pkg::COUNT_MAX : seen_len + 1;
      seen_len = 5'(len);
      if (it.last) begin
         m = '0;
         if (len >= dttp_pkg::MIN_LEN) begin
            m = done_mask & dttp_pkg::MASK_DATE;
            if (slash_pos != 0 && len == slash_pos + dttp_pkg::TAIL_LEN)
               m |= done_mask & dttp_pkg::MASK_TAIL;
         end
         res.day        = m[0] ? 7'(day_v)    : '0;
         res.month      = m[1] ? 7'(month_v)  : '0;
         res.year       = m[2] ? 14'(year_v)  : '0;
         res.hour       = m[3] ? 7'(hour_v)   : '0;
         res.minute     = m[4] ? 7'(minute_v) : '0;
         res.second     = m[5] ? 7'(second_v) : '0;
         res.fields_set = m;
         got = 1'b1;
         restart_parse();
      end
   endtask

   function automatic logic [7:0] rand_digit();
      return dttp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return rand_digit();
         4:          return dttp_pkg::CH_SLASH;
         5:          return dttp_pkg::CH_COLON;
         6:          return dttp_pkg::CH_SPACE;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly dates with random digits, most of them damaged, the rest noise
   function automatic text_q_type random_text();
      text_q_type s;
      int         pos;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: begin
            repeat ($urandom_range(1, 2)) s.push_back(rand_digit());
            s.push_back(dttp_pkg::CH_SLASH);
            repeat ($urandom_range(1, 2)) s.push_back(rand_digit());
            s.push_back(dttp_pkg::CH_SLASH);
            repeat (4) s.push_back(rand_digit());
            s.push_back(dttp_pkg::CH_SPACE);
            repeat (2) s.push_back(rand_digit());
            s.push_back(dttp_pkg::CH_COLON);
            repeat (2) s.push_back(rand_digit());
            s.push_back(dttp_pkg::CH_COLON);
            repeat (2) s.push_back(rand_digit());
            pos = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 6))
               1: s[pos] = 8'($urandom_range(0, 255));
               2: s[pos] = pick_char();
               3: repeat ($urandom_range(1, 14)) s.push_back(pick_char());
               4: while (s.size() > pos + 1) void'(s.pop_back());
               5: s.insert(pos, rand_digit());
               6: s.delete(pos);
               default: ;
            endcase
         end
         7, 8: repeat ($urandom_range(1, 34)) s.push_back(pick_char());
         default: repeat ($urandom_range(1, 16))
            s.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
      endcase
      return s;
   endfunction

   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
   endtask

   task automatic send_char(input dttp_pkg::req_type it, input bit typed,
                            input dttp_pkg::rsp_type want);
      bit                got;
      dttp_pkg::rsp_type res;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      parse_char(it, got, res);
      if (got)
         pending_dates.push_back(typed ? want : res);
   endtask

   task automatic send_text(input text_q_type s, input bit typed,
                            input dttp_pkg::rsp_type want);
      dttp_pkg::req_type it;
      foreach (s[i]) begin
         pace();
         it.character = s[i];
         it.last = (i == s.size() - 1);
         send_char(it, typed, want);
      end
      texts_sent++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("MISMATCH result %0d %s: got %0d expected %0d", dates_checked, what, got, want);
   endtask

   task automatic check_date(input dttp_pkg::rsp_type got, input dttp_pkg::rsp_type want);
      if (got.day !== want.day)       report_mismatch("day", got.day, want.day);
      if (got.month !== want.month)   report_mismatch("month", got.month, want.month);
      if (got.year !== want.year)     report_mismatch("year", got.year, want.year);
      if (got.hour !== want.hour)     report_mismatch("hour", got.hour, want.hour);
      if (got.minute !== want.minute) report_mismatch("minute", got.minute, want.minute);
      if (got.second !== want.second) report_mismatch("second", got.second, want.second);
      if (got.fields_set !== want.fields_set)
         report_mismatch("fields_set", got.fields_set, want.fields_set);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0)
            report_mismatch("unexpected result, fields_set", rsp_data.fields_set, 0);
         else
            check_date(rsp_data, pending_dates.pop_front());
         if (rsp_data.fields_set == (dttp_pkg::MASK_DATE | dttp_pkg::MASK_TAIL))
            full_dates++;
         if (rsp_data.fields_set == '0)
            empty_dates++;
         dates_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("ERROR: no request or result moved for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int mode, mode_left, hold_left, taken;
      bit held;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      taken = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            taken++;
         if (!held && taken == HOLD_AT_RESULT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 300);
         end
         mode_left--;
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      text_q_type s;
      restart_parse();
      dir_rows[0] = '{"", 8'h00, 1'b1, '0};
      dir_rows[1] = '{"", 8'hFF, 1'b1, '0};
      dir_rows[2] = '{"99/99/9999 99:99:99", 8'h00, 1'b1,
                      '{7'd99, 7'd99, 14'd9999, 7'd99, 7'd99, 7'd99,
                        dttp_pkg::MASK_DATE | dttp_pkg::MASK_TAIL}};
      dir_rows[3] = '{"1/1", 8'h00, 1'b0, '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         s = {};
         if (dir_rows[r].text.len() == 0)
            s.push_back(dir_rows[r].lone_char);
         else
            for (int i = 0; i < dir_rows[r].text.len(); i++)
               s.push_back(dir_rows[r].text[i]);
         send_text(s, dir_rows[r].typed, dir_rows[r].want);
      end

      while (chars_sent < CHAR_TARGET) begin
         if (texts_sent == PAUSE_AT_TEXT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_dates.size() != 0) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end
         send_text(random_text(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d strings in %0d characters; checked %0d dates", texts_sent,
               chars_sent, dates_checked);
      $display("Dates with every field set: %0d, with no field set: %0d", full_dates,
               empty_dates);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/dttp_pkg.sv
rtl/datetime_text_parser_top.sv
dv/datetime_text_parser_top_tb.sv
